// File: hdl/aotp_pkg.sv
package aotp_pkg;

    localparam int MaxStepsDefault = 255;

    localparam logic [2:0] RegUpFactor   = 3'd0;
    localparam logic [2:0] RegDownToN    = 3'd1;
    localparam logic [2:0] RegProbUp     = 3'd2;
    localparam logic [2:0] RegProbMid    = 3'd3;
    localparam logic [2:0] RegProbDown   = 3'd4;
    localparam logic [2:0] RegStepCount  = 3'd5;

    typedef struct packed {
        logic [31:0] spot;
        logic [31:0] strike;
        logic        func;
    } t_in;

    typedef struct packed {
        logic [31:0] option_value;
        logic        saturated;
    } t_out;

    function automatic logic [31:0] payoff(input logic [31:0] price,
                                           input logic [31:0] strike,
                                           input logic        put);
        logic [31:0] r;
        begin
            r = 32'd0;
            if (put) begin
                if (strike > price) r = strike - price;
            end else begin
                if (price > strike) r = price - strike;
            end
            return r;
        end
    endfunction

endpackage

// File: hdl/aotp_ram.sv
module aotp_ram #(
    parameter int Width = 32,
    parameter int Depth = 511
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: hdl/aotp_front.sv
module aotp_front import aotp_pkg::*; #(
    parameter int MaxSteps = MaxStepsDefault
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  t_in                         i_data,
    input  logic [7:0]                  i_step_count,
    output logic                        o_q_valid,
    input  logic                        i_q_pop,
    output t_in                         o_q_data,
    output logic [$clog2(MaxSteps+1)-1:0] o_q_steps
);
    localparam int SW = $clog2(MaxSteps + 1);

    logic [SW-1:0] w_n;
    logic [SW-1:0] r_steps [2];
    t_in           r_data  [2];
    logic [1:0]    r_cnt;
    logic          r_wp, r_rp;
    logic          w_push;

    // clamp the step count into one .. MaxSteps
    always_comb begin
        if (i_step_count == 8'd0) w_n = SW'(1);
        else if (32'(i_step_count) > 32'(MaxSteps)) w_n = SW'(MaxSteps);
        else w_n = SW'(i_step_count);
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_data  = r_data[r_rp];
    assign o_q_steps = r_steps[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
        if (w_push) begin
            r_data[r_wp]  <= i_data;
            r_steps[r_wp] <= w_n;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> o_q_valid) else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_valid |-> (o_q_steps != '0)) else $error("zero step count queued");
endmodule

// File: hdl/aotp_back.sv
module aotp_back import aotp_pkg::*; #(
    parameter int MaxSteps = MaxStepsDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    output logic                          o_q_pop,
    input  t_in                           i_q_data,
    input  logic [$clog2(MaxSteps+1)-1:0] i_q_steps,
    input  logic [31:0]                   i_up_factor,
    input  logic [28:0]                   i_down_to_steps,
    input  logic signed [31:0]            i_prob_up,
    input  logic signed [31:0]            i_prob_mid,
    input  logic signed [31:0]            i_prob_down,
    output logic                          o_valid,
    input  logic                          i_ready,
    output t_out                          o_data
);
    localparam int SW = $clog2(MaxSteps + 1);
    localparam int NodeCount = 2 * MaxSteps + 1;
    localparam int AW = $clog2(NodeCount);
    localparam int IW = AW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_P0, S_PMUL, S_PWR, S_SRD, S_SM1, S_SM2, S_SSUM, S_SWR, S_OUT
    } t_state;

    t_state r_state;
    t_in    r_req;
    logic [SW-1:0] r_n, r_step;
    logic [IW-1:0] r_i;
    logic [1:0]    r_k;
    logic          r_sat;
    logic [31:0]   r_price;
    logic [63:0]   r_prod;
    logic [31:0]   r_v [3];
    logic [31:0]   r_ex_price;
    logic signed [33:0] r_t [3];
    logic [31:0]   r_res;

    // price and value memories, one write and one read port each
    logic          w_pwe, w_vwe;
    logic [AW-1:0] w_pwa, w_pra, w_vwa, w_vra;
    logic [31:0]   w_pwd, w_vwd, w_prd, w_vrd;

    aotp_ram #(.Width(32), .Depth(NodeCount)) u_price (
        .i_clk(i_clk), .i_we(w_pwe), .i_waddr(w_pwa), .i_wdata(w_pwd),
        .i_raddr(w_pra), .o_rdata(w_prd));
    aotp_ram #(.Width(32), .Depth(NodeCount)) u_value (
        .i_clk(i_clk), .i_we(w_vwe), .i_waddr(w_vwa), .i_wdata(w_vwd),
        .i_raddr(w_vra), .o_rdata(w_vrd));

    logic [31:0] w_psat;
    logic        w_povf;
    assign w_povf = |r_prod[63:60];
    assign w_psat = w_povf ? 32'hFFFF_FFFF : r_prod[59:28];

    // one signed product per cycle, reused for all three terms
    logic signed [31:0] w_p;
    logic signed [64:0] w_mul;
    logic [31:0]        w_mv;
    always_comb begin
        case (r_k)
            2'd0:    begin w_p = i_prob_down; w_mv = r_v[0]; end
            2'd1:    begin w_p = i_prob_mid;  w_mv = r_v[1]; end
            default: begin w_p = i_prob_up;   w_mv = r_v[2]; end
        endcase
        w_mul = 65'(w_p) * $signed({1'b0, w_mv});
    end

    logic signed [35:0] w_acc;
    logic [31:0]        w_cont, w_ex;
    logic               w_csat;
    always_comb begin
        w_acc  = 36'(r_t[0]) + 36'(r_t[1]) + 36'(r_t[2]);
        w_csat = 1'b0;
        if (w_acc < 0) w_cont = 32'd0;
        else if (w_acc > 36'sh0_FFFF_FFFF) begin
            w_cont = 32'hFFFF_FFFF; w_csat = 1'b1;
        end else w_cont = w_acc[31:0];
        w_ex = payoff(r_ex_price, r_req.strike, r_req.func);
    end

    logic [IW-1:0] w_last;
    assign w_last = IW'({r_step, 1'b0});

    always_comb begin
        w_pwe = (r_state == S_PWR);
        w_pwa = r_i[AW-1:0];
        w_pwd = w_psat;
        w_vwe = (r_state == S_PWR) || (r_state == S_SWR);
        w_vwa = r_i[AW-1:0];
        w_vwd = (r_state == S_PWR) ? payoff(w_psat, r_req.strike, r_req.func)
                                   : ((w_cont > w_ex) ? w_cont : w_ex);
        w_vra = AW'(r_i + IW'(r_k));
        w_pra = AW'(r_i + IW'(r_n) - IW'(r_step));
    end

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign o_valid = (r_state == S_OUT);
    assign o_data  = '{option_value: r_res, saturated: r_sat};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: if (i_q_valid) begin
                    r_req   <= i_q_data;
                    r_n     <= i_q_steps;
                    r_sat   <= 1'b0;
                    r_i     <= '0;
                    r_state <= S_P0;
                end
                S_P0: begin
                    r_prod  <= 64'(r_req.spot) * 64'(i_down_to_steps);
                    r_state <= S_PWR;
                end
                S_PMUL: begin
                    r_prod  <= 64'(r_price) * 64'(i_up_factor);
                    r_state <= S_PWR;
                end
                S_PWR: begin
                    r_price <= w_psat;
                    if (w_povf) r_sat <= 1'b1;
                    if (r_i == IW'({r_n, 1'b0})) begin
                        r_step  <= r_n - SW'(1);
                        r_i     <= '0;
                        r_k     <= 2'd0;
                        r_state <= S_SRD;
                    end else begin
                        r_i     <= r_i + IW'(1);
                        r_state <= S_PMUL;
                    end
                end
                S_SRD: begin
                    // read three values in turn, then exercise price
                    if (r_k != 2'd0) r_v[r_k - 2'd1] <= w_vrd;
                    if (r_k == 2'd3) begin
                        r_ex_price <= w_prd;
                        r_k        <= 2'd0;
                        r_state    <= S_SM1;
                    end else r_k <= r_k + 2'd1;
                end
                S_SM1: begin
                    r_t[r_k] <= 34'(w_mul >>> 30);
                    if (r_k == 2'd2) r_state <= S_SSUM;
                    else r_k <= r_k + 2'd1;
                end
                S_SSUM: r_state <= S_SWR;
                S_SWR: begin
                    if (w_csat) r_sat <= 1'b1;
                    r_k <= 2'd0;
                    if (r_i == w_last) begin
                        if (r_step == '0) begin
                            r_state <= S_SM2;
                        end else begin
                            r_step  <= r_step - SW'(1);
                            r_i     <= '0;
                            r_state <= S_SRD;
                        end
                    end else begin
                        r_i     <= r_i + IW'(1);
                        r_state <= S_SRD;
                    end
                end
                S_SM2: begin
                    // fetch root value
                    r_i     <= '0;
                    r_k     <= 2'd0;
                    r_state <= S_OUT;
                    r_res   <= w_vwd;
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(r_res))
        else $error("result lost while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_state == S_P0) else $error("pop did not start work");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vwe |-> 32'(w_vwa) < 32'(NodeCount)) else $error("node index range");
endmodule

// File: hdl/american_option_trinomial_pricer_unit.sv
// American option pricer on an N-step trinomial lattice. A request (spot,
// strike, call/put) is taken into a two-entry queue by the front end; the
// back end builds 2N+1 terminal prices (per node one Q4.28 multiply, then
// one write), then runs backward induction over the N^2 interior nodes
// (per node four reads, three multiplies, one sum, one write), one shared
// 32x33 signed multiplier taking the three discounted probability terms in
// turn and the single-port-read node value memory setting the pace. The
// result is held in an output register until transferred, while the queue
// keeps taking new requests as long as it has room. The user must write
// registers through the configuration port only while the block is idle;
// the block itself does not enforce this.
module american_option_trinomial_pricer_unit import aotp_pkg::*; #(
    parameter int MaxSteps = MaxStepsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int SW = $clog2(MaxSteps + 1);

    logic [31:0]        r_up;
    logic [28:0]        r_dn;
    logic signed [31:0] r_pu, r_pm, r_pd;
    logic [7:0]         r_steps;

    assign o_cfg_ready = 1'b1;

    // hold configuration; an unknown index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up    <= 32'd268435456;
            r_dn    <= 29'd268435456;
            r_pu    <= 32'sd178956971;
            r_pm    <= 32'sd715827883;
            r_pd    <= 32'sd178956971;
            r_steps <= 8'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                RegUpFactor:  r_up    <= i_cfg_data;
                RegDownToN:   r_dn    <= i_cfg_data[28:0];
                RegProbUp:    r_pu    <= i_cfg_data;
                RegProbMid:   r_pm    <= i_cfg_data;
                RegProbDown:  r_pd    <= i_cfg_data;
                RegStepCount: r_steps <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    logic          w_qv, w_pop;
    t_in           w_qd;
    logic [SW-1:0] w_qs;

    aotp_front #(.MaxSteps(MaxSteps)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .i_step_count(r_steps), .o_q_valid(w_qv),
        .i_q_pop(w_pop), .o_q_data(w_qd), .o_q_steps(w_qs));

    aotp_back #(.MaxSteps(MaxSteps)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(w_qv), .o_q_pop(w_pop),
        .i_q_data(w_qd), .i_q_steps(w_qs), .i_up_factor(r_up),
        .i_down_to_steps(r_dn), .i_prob_up(r_pu), .i_prob_mid(r_pm),
        .i_prob_down(r_pd), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data));
endmodule
